@@ rtl/djs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// djs_pkg
// Shared types and constants for the dense Jacobi solver.
// ----------------------------------------------------------------------------
package djs_pkg;

    localparam int N_MAX = 16;
    localparam int IDX_W = 4;
    localparam int VAL_W = 32;
    localparam int FRAC_W = 16;

    localparam logic [1:0] CMD_LOAD_COEF = 2'd0;
    localparam logic [1:0] CMD_LOAD_RHS  = 2'd1;
    localparam logic [1:0] CMD_SOLVE     = 2'd2;

    localparam logic [1:0] ST_CONV  = 2'd0;
    localparam logic [1:0] ST_LIMIT = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;
    localparam logic [1:0] ST_INVAL = 2'd3;

    localparam logic [1:0] REG_SIZE = 2'd0;
    localparam logic [1:0] REG_SWEEPS = 2'd1;
    localparam logic [1:0] REG_MAG = 2'd2;
    localparam logic [1:0] REG_TOL = 2'd3;

    localparam logic signed [31:0] ONE_FIX = 32'sh0001_0000;
    localparam logic signed [31:0] SAT_POS = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_NEG = -32'sh7FFF_FFFF;

    // controller -> datapath
    typedef struct packed {
        logic             init;      // load 1.0 into current and previous estimates
        logic             sweep_clr; // clear sweep flags, count sweep, copy current to previous
        logic             row_start; // clear accumulator
        logic             mac;       // accumulate term j of row i
        logic             div_start; // start divider on row i
        logic             chk;       // check element i
        logic             commit;    // write divider result to current estimate of row i
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } djs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_busy;
        logic ovf;
        logic unconv;
        logic over_limit;
    } djs_stat_t;

endpackage
`default_nettype wire

@@ rtl/dense_jacobi_solver.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dense_jacobi_solver
// Jacobi solver for A*x = b in Q16.16 over up to 16 unknowns.
// Load words are accepted one per cycle while no solve is running. Each sweep
// runs n terms and a radix-2 divide per row; after the last sweep, results
// follow one word per cycle while out_ready is high. Reset clears control
// state and the configuration registers to their defaults; stores are undefined until loaded.
// ----------------------------------------------------------------------------
module dense_jacobi_solver
    import djs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         cmd,
    input  wire logic [3:0]         row_index,
    input  wire logic [3:0]         col_index,
    input  wire logic signed [31:0] operand_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [3:0]              element_index,
    output logic signed [31:0]      solution_value,
    output logic                    is_last,
    output logic [1:0]              solve_status,
    output logic [16:0]             sweep_count,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [30:0]        cfg_data
);

    logic [4:0]         size_reg;
    logic [15:0]        sweeps_reg;
    logic [30:0]        mag_reg;
    logic [15:0]        tol_reg;
    logic               acc;
    logic               go;
    logic               bad;
    logic               busy;
    logic               inval;
    logic [16:0]        sweeps;
    logic signed [31:0] rd_val;
    djs_cmd_t           dcmd;
    djs_stat_t          stat;

    assign cfg_ready = 1'b1;
    assign in_ready  = !busy;
    assign acc       = in_valid && in_ready;
    assign go        = acc && (cmd == CMD_SOLVE);
    assign bad       = (size_reg == 5'd0) || (size_reg > 5'd16) || (sweeps_reg == 16'd0)
                     || (tol_reg == 16'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg   <= 5'd16;
            sweeps_reg <= 16'd100;
            mag_reg    <= 31'h7FFF_FFFF;
            tol_reg    <= 16'd66;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SIZE:   size_reg   <= cfg_data[4:0];
                REG_SWEEPS: sweeps_reg <= cfg_data[15:0];
                REG_MAG:    mag_reg    <= cfg_data;
                REG_TOL:    tol_reg    <= cfg_data[15:0];
                default:    size_reg   <= size_reg;
            endcase
        end
    end

    djs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ld_coef   (acc && (cmd == CMD_LOAD_COEF)),
        .ld_rhs    (acc && (cmd == CMD_LOAD_RHS)),
        .ld_row    (row_index),
        .ld_col    (col_index),
        .ld_val    (operand_value),
        .cmd       (dcmd),
        .mag_lim   (mag_reg),
        .tol       (tol_reg),
        .sweep_lim (sweeps_reg),
        .rd_idx    (element_index),
        .rd_val    (rd_val),
        .sweeps    (sweeps),
        .stat      (stat)
    );

    djs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .bad       (bad),
        .n         (size_reg),
        .stat      (stat),
        .out_taken (out_ready),
        .cmd       (dcmd),
        .busy      (busy),
        .out_valid (out_valid),
        .out_idx   (element_index),
        .out_last  (is_last),
        .out_inval (inval)
    );

    assign solution_value = inval ? 32'sd0 : rd_val;
    assign solve_status   = inval ? ST_INVAL : (stat.ovf ? ST_OVF :
                            (!stat.unconv ? ST_CONV : ST_LIMIT));
    assign sweep_count    = inval ? 17'd0 : sweeps;

endmodule
`default_nettype wire

@@ rtl/djs_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// djs_divider
// Radix-2 restoring divider: 64-bit dividend over 32-bit divisor, 32-bit
// quotient. The upper dividend half must be below the divisor.
// ----------------------------------------------------------------------------
module djs_divider
    import djs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [31:0] den,
    output logic             busy,
    output logic [31:0]      quot
);

    logic [5:0]  cnt_reg;
    logic [31:0] q_reg;
    logic [32:0] rem_reg;
    logic [31:0] den_reg;
    logic [32:0] trial;
    logic [32:0] shifted;

    assign shifted = {rem_reg[31:0], q_reg[31]};
    assign trial   = shifted - {1'b0, den_reg};
    assign busy    = (cnt_reg != 6'd0);
    assign quot    = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 6'd0;
        end
        else if (start)
        begin
            cnt_reg <= 6'd32;
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num[31:0];
            rem_reg <= {1'b0, num[63:32]};
            den_reg <= den;
        end
        else if (busy)
        begin
            if (!trial[32])
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg   <= {q_reg[30:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/djs_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// djs_datapath
// Stores, multiply-accumulate, divider, convergence and overflow checks.
// ----------------------------------------------------------------------------
module djs_datapath
    import djs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               ld_coef,
    input  wire logic               ld_rhs,
    input  wire logic [IDX_W-1:0]   ld_row,
    input  wire logic [IDX_W-1:0]   ld_col,
    input  wire logic signed [31:0] ld_val,
    input  wire djs_cmd_t           cmd,
    input  wire logic [30:0]        mag_lim,
    input  wire logic [15:0]        tol,
    input  wire logic [15:0]        sweep_lim,
    input  wire logic [IDX_W-1:0]   rd_idx,
    output logic signed [31:0]      rd_val,
    output logic [16:0]             sweeps,
    output djs_stat_t               stat
);

    logic signed [31:0] coef_mem [N_MAX*N_MAX];
    logic signed [31:0] rhs_mem [N_MAX];
    logic signed [31:0] cur_reg [N_MAX];
    logic signed [31:0] prev_reg [N_MAX];
    logic signed [31:0] coef_rd_reg;
    logic signed [51:0] acc_reg;
    logic [16:0]        sweep_reg;
    logic               ovf_reg;
    logic               unconv_reg;
    logic               neg_reg;
    logic               sign_num_reg;
    logic               den_zero_reg;
    logic               div_wait_reg;
    logic [IDX_W-1:0]   drow_reg;
    logic               mac_d_reg;
    logic [IDX_W-1:0]   mcol_reg;

    logic signed [63:0] prod;
    logic [63:0]        pmag;
    logic signed [47:0] term;
    logic signed [52:0] numer;
    logic [52:0]        nmag;
    logic [31:0]        dmag;
    logic               div_busy;
    logic [31:0]        quot;
    logic signed [31:0] res;
    logic signed [32:0] xn;
    logic [32:0]        xnm;
    logic signed [33:0] diff;
    logic [33:0]        dm;
    logic [49:0]        lhs;
    logic [48:0]        rhs;
    logic               ok;

    // coefficient fetch: register read at (row, col)
    always_ff @(posedge clk)
    begin
        if (ld_coef)
        begin
            coef_mem[{ld_row, ld_col}] <= ld_val;
        end
        if (ld_rhs)
        begin
            rhs_mem[ld_row] <= ld_val;
        end
        coef_rd_reg <= coef_mem[{cmd.row, cmd.col}];
        mcol_reg    <= cmd.col;
    end

    assign prod  = coef_rd_reg * prev_reg[mcol_reg];
    assign pmag  = prod[63] ? (64'd0 - prod) : prod;
    assign term  = prod[63] ? -$signed({1'b0, pmag[62:16]}) : $signed({1'b0, pmag[62:16]});
    assign numer = $signed({{21{rhs_mem[cmd.row][31]}}, rhs_mem[cmd.row]})
                 - $signed({acc_reg[51], acc_reg});
    assign nmag  = numer[52] ? (53'd0 - numer) : numer;
    assign dmag  = coef_rd_reg[31] ? (32'd0 - coef_rd_reg) : coef_rd_reg;

    djs_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   ({nmag[47:0], 16'd0}),
        .den   (dmag),
        .busy  (div_busy),
        .quot  (quot)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            neg_reg      <= numer[52] ^ coef_rd_reg[31];
            sign_num_reg <= numer[52];
            den_zero_reg <= (coef_rd_reg == 32'sd0);
            // |num| >= |den| * 2^15 overflows
            div_wait_reg <= (nmag >= {6'd0, dmag, 15'd0}) ? 1'b1 : 1'b0;
        end
    end

    always_comb
    begin
        if (den_zero_reg)
        begin
            res = sign_num_reg ? SAT_NEG : SAT_POS;
        end
        else if (div_wait_reg)
        begin
            res = neg_reg ? SAT_NEG : SAT_POS;
        end
        else
        begin
            res = neg_reg ? -$signed(quot) : $signed(quot);
        end
    end

    assign xn   = {cur_reg[cmd.row][31], cur_reg[cmd.row]};
    assign xnm  = xn[32] ? (33'd0 - xn) : xn;
    assign diff = {xn[32], xn} - {{2{prev_reg[cmd.row][31]}}, prev_reg[cmd.row]};
    assign dm   = diff[33] ? (34'd0 - diff) : diff;
    assign lhs  = {dm, 16'd0};
    assign rhs  = tol * xnm;
    assign ok   = (xn == 33'sd0) ? (dm == 34'd0) : ({1'b0, rhs} > lhs);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg  <= 17'd0;
            ovf_reg    <= 1'b0;
            unconv_reg <= 1'b0;
            mac_d_reg  <= 1'b0;
            drow_reg   <= '0;
            for (int k = 0; k < N_MAX; k++)
            begin
                cur_reg[k] <= 32'sd0;
            end
        end
        else
        begin
            mac_d_reg <= cmd.mac && (cmd.col != cmd.row);
            if (cmd.init)
            begin
                sweep_reg <= 17'd0;
                ovf_reg   <= 1'b0;
                for (int k = 0; k < N_MAX; k++)
                begin
                    cur_reg[k] <= ONE_FIX;
                end
            end
            if (cmd.sweep_clr)
            begin
                unconv_reg <= 1'b0;
                sweep_reg  <= sweep_reg + 17'd1;
            end
            if (cmd.div_start)
            begin
                drow_reg <= cmd.row;
            end
            if (cmd.commit)
            begin
                cur_reg[drow_reg] <= res;
                if (den_zero_reg || div_wait_reg)
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.chk)
            begin
                if (!ok)
                begin
                    unconv_reg <= 1'b1;
                end
                if ((xn >= $signed({2'b00, mag_lim})) || (xn <= -$signed({2'b00, mag_lim})))
                begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.row_start)
        begin
            acc_reg <= 52'sd0;
        end
        else if (mac_d_reg)
        begin
            acc_reg <= acc_reg + {{4{term[47]}}, term};
        end
        for (int k = 0; k < N_MAX; k++)
        begin
            if (cmd.init)
            begin
                prev_reg[k] <= ONE_FIX;
            end
            else if (cmd.sweep_clr && !cmd.init)
            begin
                prev_reg[k] <= cur_reg[k];
            end
        end
    end

    assign rd_val = cur_reg[rd_idx];
    assign sweeps = sweep_reg;
    assign stat.div_busy   = div_busy;
    assign stat.ovf        = ovf_reg;
    assign stat.unconv     = unconv_reg;
    assign stat.over_limit = (sweep_reg > {1'b0, sweep_lim});

endmodule
`default_nettype wire

@@ rtl/djs_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// djs_ctrl
// Sequencer for sweeps, rows, terms, checks and result output.
// ----------------------------------------------------------------------------
module djs_ctrl
    import djs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             go,
    input  wire logic             bad,
    input  wire logic [4:0]       n,
    input  wire djs_stat_t        stat,
    input  wire logic             out_taken,
    output djs_cmd_t              cmd,
    output logic                  busy,
    output logic                  out_valid,
    output logic [IDX_W-1:0]      out_idx,
    output logic                  out_last,
    output logic                  out_inval
);

    typedef enum logic [3:0] {
        S_IDLE, S_SWEEP, S_ROW, S_MAC, S_MACW, S_DIV, S_DIVW, S_WB,
        S_CHK, S_CHKW, S_DEC, S_OUT
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] last_idx;
    logic             inval_reg;

    assign last_idx = n[IDX_W-1:0] - {{(IDX_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        cmd           = '0;
        cmd.row       = i_reg;
        cmd.col       = j_reg;
        cmd.init      = (state_reg == S_IDLE) && go && !bad;
        cmd.sweep_clr = (state_reg == S_SWEEP);
        cmd.row_start = (state_reg == S_ROW);
        cmd.mac       = (state_reg == S_MAC);
        cmd.div_start = (state_reg == S_DIV);
        cmd.commit    = 1'b0;
        cmd.chk       = (state_reg == S_CHK);
        // diagonal fetched in S_MACW, the state just before the divider start
        if (state_reg == S_MACW)
        begin
            cmd.col = i_reg;
        end
        if (state_reg == S_WB)
        begin
            cmd.commit = 1'b1;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_idx   = inval_reg ? '0 : i_reg;
    assign out_last  = inval_reg || (i_reg == last_idx);
    assign out_inval = inval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            inval_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    i_reg <= '0;
                    if (go)
                    begin
                        inval_reg <= bad;
                        state_reg <= bad ? S_OUT : S_SWEEP;
                    end
                end
                S_SWEEP:
                begin
                    i_reg     <= '0;
                    state_reg <= S_ROW;
                end
                S_ROW:
                begin
                    j_reg     <= '0;
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    j_reg <= j_reg + 1'b1;
                    if (j_reg == last_idx)
                    begin
                        state_reg <= S_MACW;
                    end
                end
                S_MACW:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    state_reg <= S_DIVW;
                end
                S_DIVW:
                begin
                    if (!stat.div_busy)
                    begin
                        state_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    if (i_reg == last_idx)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_CHK;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_ROW;
                    end
                end
                S_CHK:
                begin
                    if (i_reg == last_idx)
                    begin
                        state_reg <= S_CHKW;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_CHKW:
                begin
                    state_reg <= S_DEC;
                end
                S_DEC:
                begin
                    i_reg <= '0;
                    if (stat.ovf || !stat.unconv || stat.over_limit)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_SWEEP;
                    end
                end
                S_OUT:
                begin
                    if (out_taken)
                    begin
                        if (out_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
